@@ hdl/steq_pkg.sv @@
// steq_pkg: shared types and constants of the sorted timer event queue
// no dependencies; used by steq_ctrl, steq_datapath and the top level
`default_nettype none
package steq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int TIME_W          = 48;
  localparam int ID_W            = 16;
  localparam int DELAY_W         = 32;
  localparam int MAX_FIRES       = 16;
  localparam int FIRE_W          = $clog2(MAX_FIRES + 1);

  typedef enum logic [1:0] {
    KIND_SCHED  = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED_ADD,
    ST_SCHED_INS,
    ST_POP,
    ST_REIN_ADD,
    ST_REIN_INS
  } state_t;

  typedef struct packed {
    logic latch;
    logic sched_add;
    logic sched_ins;
    logic pop;
    logic none_due;
    logic rein_load;
    logic rein_ins;
  } cmd_t;

  typedef struct packed {
    logic is_update;
    logic front_due;
    logic pop_last;
    logic rein_done;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/steq_ctrl.sv @@
// steq_ctrl: sequencer for schedule, expiry pass and reinsertion
// depends on steq_pkg for state, command and status types
`default_nettype none
module steq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire steq_pkg::status_t sts,
  output steq_pkg::cmd_t         cmd,
  output logic                   busy
);

  steq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= steq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      steq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = sts.is_update ? steq_pkg::ST_POP : steq_pkg::ST_SCHED_ADD;
        end
      end
      steq_pkg::ST_SCHED_ADD: state_nxt = steq_pkg::ST_SCHED_INS;
      steq_pkg::ST_SCHED_INS: state_nxt = steq_pkg::ST_IDLE;
      steq_pkg::ST_POP: begin
        if (!sts.front_due) begin
          state_nxt = steq_pkg::ST_IDLE;
        end else if (sts.pop_last) begin
          state_nxt = steq_pkg::ST_REIN_ADD;
        end
      end
      steq_pkg::ST_REIN_ADD: begin
        state_nxt = sts.rein_done ? steq_pkg::ST_IDLE : steq_pkg::ST_REIN_INS;
      end
      steq_pkg::ST_REIN_INS: state_nxt = steq_pkg::ST_REIN_ADD;
      default: state_nxt = steq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      steq_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      steq_pkg::ST_SCHED_ADD: cmd.sched_add = 1'b1;
      steq_pkg::ST_SCHED_INS: cmd.sched_ins = 1'b1;
      steq_pkg::ST_POP: begin
        cmd.pop      = sts.front_due;
        cmd.none_due = !sts.front_due;
      end
      steq_pkg::ST_REIN_ADD: cmd.rein_load = !sts.rein_done;
      steq_pkg::ST_REIN_INS: cmd.rein_ins = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/steq_datapath.sv @@
// steq_datapath: sorted entry registers, popped-entry buffer, saturating adder
// and result registers; depends on steq_pkg
`default_nettype none
module steq_datapath #(
  parameter int QUEUE_DEPTH = steq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = steq_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire steq_pkg::cmd_t                cmd,
  output steq_pkg::status_t                  sts,
  input  wire logic                          in_opcode,
  input  wire logic [steq_pkg::TIME_W-1:0]   in_time_now,
  input  wire logic [steq_pkg::ID_W-1:0]     in_event_id,
  input  wire logic [steq_pkg::DELAY_W-1:0]  in_delay_ms,
  input  wire logic                          in_cyclic,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [steq_pkg::ID_W-1:0]          out_fired_id,
  output logic [steq_pkg::TIME_W-1:0]        out_deadline,
  output logic                               out_last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FW    = steq_pkg::FIRE_W;
  localparam int PI_W  = $clog2(steq_pkg::MAX_FIRES);

  // input item latches
  logic [TIME_BITS-1:0]          now_r;
  logic [steq_pkg::ID_W-1:0]     id_r;
  logic [steq_pkg::DELAY_W-1:0]  delay_r;
  logic                          cyc_r;

  // sorted table
  logic [TIME_BITS-1:0]          dl_q  [QUEUE_DEPTH];
  logic [steq_pkg::ID_W-1:0]     ev_q  [QUEUE_DEPTH];
  logic [steq_pkg::DELAY_W-1:0]  per_q [QUEUE_DEPTH];
  logic [CNT_W-1:0]              count_r;

  // entries popped in this pass
  logic [TIME_BITS-1:0]          pdl_q  [steq_pkg::MAX_FIRES];
  logic [steq_pkg::ID_W-1:0]     pid_q  [steq_pkg::MAX_FIRES];
  logic [steq_pkg::DELAY_W-1:0]  pper_q [steq_pkg::MAX_FIRES];
  logic [FW-1:0]                 n_r;
  logic [FW-1:0]                 ri_r;

  logic [TIME_BITS-1:0]          dl_r;
  logic [steq_pkg::ID_W-1:0]     rid_r;
  logic [steq_pkg::DELAY_W-1:0]  rper_r;

  logic                          valid_r;
  steq_pkg::kind_t               kind_r;
  logic [steq_pkg::ID_W-1:0]     oid_r;
  logic [TIME_BITS-1:0]          odl_r;
  logic                          last_r;

  // shared saturating adder
  logic [TIME_BITS-1:0]          add_a;
  logic [steq_pkg::DELAY_W-1:0]  add_b;
  logic [TIME_BITS:0]            add_sum;
  logic [TIME_BITS-1:0]          add_sat;

  logic                          full;
  logic                          ins_en;
  logic [TIME_BITS-1:0]          ins_dl;
  logic [steq_pkg::ID_W-1:0]     ins_id;
  logic [steq_pkg::DELAY_W-1:0]  ins_per;
  logic [QUEUE_DEPTH-1:0]        gt;
  logic [PI_W-1:0]               ri_idx;
  logic [PI_W-1:0]               n_idx;

  assign ri_idx = ri_r[PI_W-1:0];
  assign n_idx  = n_r[PI_W-1:0];

  always_comb begin
    if (cmd.sched_add) begin
      add_a = now_r;
      add_b = delay_r;
    end else begin
      add_a = pdl_q[ri_idx];
      add_b = pper_q[ri_idx];
    end
    add_sum = {1'b0, add_a} + (TIME_BITS + 1)'(add_b);
    add_sat = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];
  end

  assign full = (count_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    if (cmd.sched_ins) begin
      ins_dl  = dl_r;
      ins_id  = id_r;
      ins_per = cyc_r ? delay_r : '0;
      ins_en  = !full;
    end else begin
      ins_dl  = dl_r;
      ins_id  = rid_r;
      ins_per = rper_r;
      ins_en  = cmd.rein_ins && (rper_r != '0) && !full;
    end
  end

  // entries strictly later than the new one move up; equal ones stay ahead
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count_r) && (ins_dl < dl_q[i]);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    logic shift_in;
    logic here;
    if (g == 0) begin : g_first
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign shift_in = gt[g-1];
    end
    assign here = !shift_in && (gt[g] || (CNT_W'(g) == count_r));

    always_ff @(posedge clk) begin
      if (cmd.pop) begin
        if (g < QUEUE_DEPTH - 1) begin
          dl_q[g]  <= dl_q[(g + 1) % QUEUE_DEPTH];
          ev_q[g]  <= ev_q[(g + 1) % QUEUE_DEPTH];
          per_q[g] <= per_q[(g + 1) % QUEUE_DEPTH];
        end
      end else if (ins_en) begin
        if (shift_in) begin
          dl_q[g]  <= dl_q[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          ev_q[g]  <= ev_q[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
          per_q[g] <= per_q[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
        end else if (here) begin
          dl_q[g]  <= ins_dl;
          ev_q[g]  <= ins_id;
          per_q[g] <= ins_per;
        end
      end
    end
  end

  always_comb begin
    sts.is_update = in_opcode;
    sts.front_due = (count_r != '0) && (dl_q[0] < now_r) &&
                    (n_r != FW'(steq_pkg::MAX_FIRES));
    sts.pop_last  = !((count_r > CNT_W'(1)) && (dl_q[1] < now_r) &&
                      ((n_r + FW'(1)) != FW'(steq_pkg::MAX_FIRES)));
    sts.rein_done = (ri_r == n_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      now_r   <= TIME_BITS'(in_time_now);
      id_r    <= in_event_id;
      delay_r <= in_delay_ms;
      cyc_r   <= in_cyclic;
    end
    if (cmd.sched_add || cmd.rein_load) begin
      dl_r <= add_sat;
    end
    if (cmd.rein_load) begin
      rid_r  <= pid_q[ri_idx];
      rper_r <= pper_q[ri_idx];
    end
    if (cmd.pop) begin
      pdl_q[n_idx]  <= dl_q[0];
      pid_q[n_idx]  <= ev_q[0];
      pper_q[n_idx] <= per_q[0];
    end
    if (cmd.sched_ins) begin
      kind_r <= full ? steq_pkg::KIND_REJECT : steq_pkg::KIND_SCHED;
      oid_r  <= id_r;
      odl_r  <= dl_r;
      last_r <= 1'b1;
    end else if (cmd.pop) begin
      kind_r <= steq_pkg::KIND_FIRED;
      oid_r  <= ev_q[0];
      odl_r  <= dl_q[0];
      last_r <= sts.pop_last;
    end else if (cmd.none_due) begin
      kind_r <= steq_pkg::KIND_NONE;
      oid_r  <= '0;
      odl_r  <= '0;
      last_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      n_r     <= '0;
      ri_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.sched_ins || cmd.pop || cmd.none_due;
      if (cmd.latch) begin
        n_r  <= '0;
        ri_r <= '0;
      end
      if (cmd.pop) begin
        count_r <= count_r - CNT_W'(1);
        n_r     <= n_r + FW'(1);
      end else if (ins_en && (cmd.sched_ins || cmd.rein_ins)) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.rein_ins) begin
        ri_r <= ri_r + FW'(1);
      end
    end
  end

  assign out_valid    = valid_r;
  assign out_kind     = kind_r;
  assign out_fired_id = oid_r;
  assign out_deadline = steq_pkg::TIME_W'(odl_r);
  assign out_last     = last_r;

endmodule
`default_nettype wire

@@ hdl/sorted_timer_event_queue.sv @@
// sorted_timer_event_queue: top level, joins sequencer and datapath
// depends on steq_pkg, steq_ctrl, steq_datapath
//
// usage:
//   an item is taken at a clock edge where start is high and busy is low.
//   in_opcode 0 schedules in_event_id at in_time_now + in_delay_ms (saturating);
//   in_opcode 1 fires every front entry whose deadline is below in_time_now,
//   at most sixteen per item, then reinserts cyclic ones with deadline + period.
//   results come out on out_* with out_valid high for exactly one cycle each;
//   out_last marks the final result of an item. the receiver cannot stall.
//   sequence: a schedule holds busy through its add and insert states, and its
//   result is registered at the end of the insert state. an update holds busy
//   while it pops one due entry per cycle, then runs a load and an insert state
//   per popped entry and a final load state; nothing due holds busy only in the
//   pop state. fired results come one per cycle, each registered from its pop.
//   the sorted table is a row of registers; an insert is one parallel compare
//   and shift step, so the pop and reinsert sequence sets the item time.
//   reset empties the table; no clearing pass is needed.
`default_nettype none
module sorted_timer_event_queue #(
  parameter int QUEUE_DEPTH = steq_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = steq_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_opcode,
  input  wire logic [steq_pkg::TIME_W-1:0]   in_time_now,
  input  wire logic [steq_pkg::ID_W-1:0]     in_event_id,
  input  wire logic [steq_pkg::DELAY_W-1:0]  in_delay_ms,
  input  wire logic                          in_cyclic,
  output logic                               out_valid,
  output logic [1:0]                         out_kind,
  output logic [steq_pkg::ID_W-1:0]          out_fired_id,
  output logic [steq_pkg::TIME_W-1:0]        out_deadline,
  output logic                               out_last
);

  steq_pkg::cmd_t    cmd;
  steq_pkg::status_t sts;

  steq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  steq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_opcode),
    .in_time_now  (in_time_now),
    .in_event_id  (in_event_id),
    .in_delay_ms  (in_delay_ms),
    .in_cyclic    (in_cyclic),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_fired_id (out_fired_id),
    .out_deadline (out_deadline),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire

@@ hdl/steq_checker.sv @@
// steq_checker: port-level assertions for sorted_timer_event_queue
// depends on steq_pkg; bound to the top level below
`default_nettype none
module steq_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic [1:0]                   out_kind,
  input wire logic [steq_pkg::ID_W-1:0]    out_fired_id,
  input wire logic [steq_pkg::TIME_W-1:0]  out_deadline,
  input wire logic                         out_last
);

  // an accepted item always makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  // results only follow a busy cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in flight");

  // schedule, reject and nothing-due are single results
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == steq_pkg::KIND_SCHED || out_kind == steq_pkg::KIND_REJECT ||
                  out_kind == steq_pkg::KIND_NONE) |-> out_last)
    else $error("single result without last");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == steq_pkg::KIND_NONE |-> out_fired_id == '0 && out_deadline == '0)
    else $error("nothing-due result carries data");

  // single results come when the block is idle again; fired ones precede reinsertion
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_kind != steq_pkg::KIND_FIRED |-> !busy)
    else $error("still busy after last result");

endmodule

bind sorted_timer_event_queue steq_checker u_steq_checker (.*);
`default_nettype wire
